// ----- sv/mtf_pkg.sv -----
`default_nettype none

package mtf_pkg;

  localparam int unsigned CAP   = 10;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned KEY_W = 32;

  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAP);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_SWITCH = 2'd1,
    OP_LOAD   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_end;
    logic match;
    logic is_read;
  } stat_t;

endpackage

`default_nettype wire

// ----- sv/mtf_ctrl.sv -----
`default_nettype none

module mtf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire mtf_pkg::stat_t stat_i,
  output mtf_pkg::cmd_t      cmd_o,
  output logic               busy_o,
  output logic               valid_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.scan  = 1'b0;
    cmd_o.apply = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.is_read || stat_i.at_end || stat_i.match) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = (state_q == S_RESP);

endmodule

`default_nettype wire

// ----- sv/mtf_datapath.sv -----
`default_nettype none

module mtf_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mtf_pkg::cmd_t                 cmd_i,
  output mtf_pkg::stat_t                     stat_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [mtf_pkg::KEY_W-1:0]     name_key_i,
  input  wire logic [mtf_pkg::KEY_W-1:0]     path_key_i,
  input  wire logic signed [mtf_pkg::KEY_W-1:0] model_version_i,
  input  wire logic                          load_ok_i,
  input  wire logic [mtf_pkg::IDX_W-1:0]     slot_index_i,
  output logic [1:0]                         status_o,
  output logic [mtf_pkg::IDX_W-1:0]          slot_o,
  output logic                               start_load_o,
  output logic                               evicted_o,
  output logic [mtf_pkg::KEY_W-1:0]          entry_name_o,
  output logic [mtf_pkg::KEY_W-1:0]          entry_path_o,
  output logic signed [mtf_pkg::KEY_W-1:0]   entry_version_o,
  output logic                               entry_loaded_o,
  output logic                               entry_active_o,
  output logic [mtf_pkg::CNT_W-1:0]          fill_o
);

  // entry storage, position 0 is most recent
  logic [mtf_pkg::KEY_W-1:0] names_q    [mtf_pkg::CAP];
  logic [mtf_pkg::KEY_W-1:0] paths_q    [mtf_pkg::CAP];
  logic [mtf_pkg::KEY_W-1:0] versions_q [mtf_pkg::CAP];
  logic [mtf_pkg::CAP-1:0]   loaded_q;
  logic [mtf_pkg::CAP-1:0]   active_q;
  logic [mtf_pkg::CNT_W-1:0] count_q;

  // latched command
  mtf_pkg::op_e              op_q;
  logic [mtf_pkg::KEY_W-1:0] nkey_q, pkey_q, ver_q;
  logic                      ok_q;
  logic [mtf_pkg::IDX_W-1:0] idx_q;
  logic                      hit_q;

  // registered result beat
  logic [1:0]                status_q;
  logic [mtf_pkg::IDX_W-1:0] slot_q;
  logic                      start_load_q, evicted_q;
  logic [mtf_pkg::KEY_W-1:0] ename_q, epath_q, ever_q;
  logic                      eloaded_q, eactive_q;
  logic [mtf_pkg::CNT_W-1:0] fill_q;

  logic                      idx_ok;
  logic [mtf_pkg::KEY_W-1:0] rd_name, rd_path, rd_ver;
  logic                      rd_loaded, rd_active;
  logic                      at_end, match, full;
  logic                      add_new, sw_ok;
  logic [mtf_pkg::IDX_W-1:0] shift_top;
  logic [mtf_pkg::KEY_W-1:0] head_name, head_path, head_ver;
  logic                      head_loaded, head_active;
  logic [mtf_pkg::CNT_W-1:0] count_after;

  // single variable read port at the scan / read position
  assign idx_ok    = (idx_q < mtf_pkg::IDX_W'(mtf_pkg::CAP));
  assign rd_name   = idx_ok ? names_q[idx_q]    : '0;
  assign rd_path   = idx_ok ? paths_q[idx_q]    : '0;
  assign rd_ver    = idx_ok ? versions_q[idx_q] : '0;
  assign rd_loaded = idx_ok ? loaded_q[idx_q]   : 1'b0;
  assign rd_active = idx_ok ? active_q[idx_q]   : 1'b0;

  assign at_end = (idx_q == count_q);
  assign full   = (count_q == mtf_pkg::CapCnt);

  always_comb begin
    unique case (op_q)
      mtf_pkg::OP_ADD:    match = (rd_name == nkey_q) || (rd_path == pkey_q);
      mtf_pkg::OP_SWITCH: match = (rd_name == nkey_q);
      mtf_pkg::OP_LOAD:   match = !rd_loaded;
      mtf_pkg::OP_READ:   match = 1'b0;
      default:            match = 1'b0;
    endcase
  end

  assign stat_o.at_end  = at_end;
  assign stat_o.match   = match;
  assign stat_o.is_read = (op_q == mtf_pkg::OP_READ);

  assign add_new   = !hit_q;
  assign sw_ok     = hit_q && (rd_loaded || ok_q);
  assign shift_top = hit_q ? idx_q : (full ? mtf_pkg::IDX_W'(mtf_pkg::CAP - 1) : count_q);

  assign head_name   = hit_q ? rd_name   : nkey_q;
  assign head_path   = hit_q ? rd_path   : pkey_q;
  assign head_ver    = hit_q ? rd_ver    : ver_q;
  assign head_loaded = hit_q ? rd_loaded : 1'b0;
  assign head_active = hit_q ? rd_active : 1'b0;

  assign count_after = (op_q == mtf_pkg::OP_ADD && add_new) ?
                       (full ? mtf_pkg::CapCnt : mtf_pkg::CNT_W'(count_q + 1'b1)) : count_q;

  // command capture and scan pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= mtf_pkg::op_e'(opcode_i);
      nkey_q <= name_key_i;
      pkey_q <= path_key_i;
      ver_q  <= model_version_i;
      ok_q   <= load_ok_i;
      idx_q  <= (mtf_pkg::op_e'(opcode_i) == mtf_pkg::OP_READ) ? slot_index_i : '0;
    end else if (cmd_i.scan) begin
      hit_q <= match && !at_end;
      if (!match && !at_end && op_q != mtf_pkg::OP_READ) begin
        idx_q <= mtf_pkg::IDX_W'(idx_q + 1'b1);
      end
    end
  end

  // key and version words, shifted toward the back on add
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && op_q == mtf_pkg::OP_ADD) begin
      for (int k = 1; k < mtf_pkg::CAP; k++) begin
        if (mtf_pkg::IDX_W'(k) <= shift_top) begin
          names_q[k]    <= names_q[k-1];
          paths_q[k]    <= paths_q[k-1];
          versions_q[k] <= versions_q[k-1];
        end
      end
      names_q[0]    <= head_name;
      paths_q[0]    <= head_path;
      versions_q[0] <= head_ver;
    end
  end

  // flags and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      active_q <= '0;
      count_q  <= '0;
    end else if (cmd_i.apply) begin
      count_q <= count_after;
      case (op_q)
        mtf_pkg::OP_ADD: begin
          for (int k = 1; k < mtf_pkg::CAP; k++) begin
            if (mtf_pkg::IDX_W'(k) <= shift_top) begin
              loaded_q[k] <= loaded_q[k-1];
              active_q[k] <= active_q[k-1];
            end
          end
          loaded_q[0] <= head_loaded;
          active_q[0] <= head_active;
        end
        mtf_pkg::OP_SWITCH: begin
          if (sw_ok) begin
            loaded_q[idx_q] <= 1'b1;
            for (int k = 0; k < mtf_pkg::CAP; k++) begin
              active_q[k] <= (mtf_pkg::IDX_W'(k) == idx_q);
            end
          end
        end
        mtf_pkg::OP_LOAD: begin
          if (hit_q) begin
            loaded_q[idx_q] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      status_q     <= mtf_pkg::ST_OK;
      slot_q       <= '0;
      start_load_q <= 1'b0;
      evicted_q    <= 1'b0;
      ename_q      <= '0;
      epath_q      <= '0;
      ever_q       <= '0;
      eloaded_q    <= 1'b0;
      eactive_q    <= 1'b0;
      fill_q       <= count_after;
      case (op_q)
        mtf_pkg::OP_ADD: begin
          if (hit_q) begin
            slot_q <= idx_q;
          end else begin
            start_load_q <= 1'b1;
            evicted_q    <= full;
          end
        end
        mtf_pkg::OP_SWITCH: begin
          if (!hit_q) begin
            status_q <= mtf_pkg::ST_FAIL;
          end else begin
            slot_q <= idx_q;
            if (!sw_ok) begin
              status_q <= mtf_pkg::ST_FAIL;
            end
          end
        end
        mtf_pkg::OP_LOAD: begin
          if (hit_q) begin
            slot_q <= idx_q;
          end else begin
            status_q <= mtf_pkg::ST_FAIL;
          end
        end
        default: begin
          slot_q <= idx_q;
          if (idx_q >= count_q) begin
            status_q <= mtf_pkg::ST_RANGE;
          end else begin
            ename_q   <= rd_name;
            epath_q   <= rd_path;
            ever_q    <= rd_ver;
            eloaded_q <= rd_loaded;
            eactive_q <= rd_active;
          end
        end
      endcase
    end
  end

  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign start_load_o    = start_load_q;
  assign evicted_o       = evicted_q;
  assign entry_name_o    = ename_q;
  assign entry_path_o    = epath_q;
  assign entry_version_o = ever_q;
  assign entry_loaded_o  = eloaded_q;
  assign entry_active_o  = eactive_q;
  assign fill_o          = fill_q;

endmodule

`default_nettype wire

// ----- sv/move_to_front_recent_list_top.sv -----
`default_nettype none

// move-to-front recently-used list of up to ten entries, position 0 most recent.
// a command beat is taken when start_i is high and busy_o is low; its single
// result beat shows on the result ports for exactly one cycle with valid_o high,
// and the receiver cannot stall it, so it must take every beat as it comes.
// add, switch and load-done walk the list one entry per cycle through a single
// compare unit until a hit or the end of the filled part, passing up to ten
// entries when nothing matches in a full list; read goes straight to its slot
// without a walk. busy_o stays high until the result beat has been shown, so
// no new command is taken before then. entries not yet written are never read
// out.

module move_to_front_recent_list_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [1:0]                       opcode_i,
  input  wire logic [mtf_pkg::KEY_W-1:0]        name_key_i,
  input  wire logic [mtf_pkg::KEY_W-1:0]        path_key_i,
  input  wire logic signed [mtf_pkg::KEY_W-1:0] model_version_i,
  input  wire logic                             load_ok_i,
  input  wire logic [mtf_pkg::IDX_W-1:0]        slot_index_i,
  output logic                                  valid_o,
  output logic [1:0]                            status_o,
  output logic [mtf_pkg::IDX_W-1:0]             slot_o,
  output logic                                  start_load_o,
  output logic                                  evicted_o,
  output logic [mtf_pkg::KEY_W-1:0]             entry_name_o,
  output logic [mtf_pkg::KEY_W-1:0]             entry_path_o,
  output logic signed [mtf_pkg::KEY_W-1:0]      entry_version_o,
  output logic                                  entry_loaded_o,
  output logic                                  entry_active_o,
  output logic [mtf_pkg::CNT_W-1:0]             fill_o
);

  // command and status between sequencer and entry datapath
  mtf_pkg::cmd_t  cmd;
  mtf_pkg::stat_t stat;

  // sequencer: idle, scan, apply, result beat
  mtf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .valid_o (valid_o)
  );

  // entry registers, compare unit, shift network and result registers
  mtf_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (opcode_i),
    .name_key_i      (name_key_i),
    .path_key_i      (path_key_i),
    .model_version_i (model_version_i),
    .load_ok_i       (load_ok_i),
    .slot_index_i    (slot_index_i),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .start_load_o    (start_load_o),
    .evicted_o       (evicted_o),
    .entry_name_o    (entry_name_o),
    .entry_path_o    (entry_path_o),
    .entry_version_o (entry_version_o),
    .entry_loaded_o  (entry_loaded_o),
    .entry_active_o  (entry_active_o),
    .fill_o          (fill_o)
  );

`ifndef ASSERT_OFF
  // a result beat only appears while the command is still owned
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result beat without busy");

  // an accepted command holds off the next one
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accept");

  // fill never exceeds capacity
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (fill_o <= mtf_pkg::CapCnt))
    else $error("fill above capacity");

  // a fresh insert always lands at the front and succeeds
  a_insert_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && start_load_o) |-> (slot_o == '0 && status_o == mtf_pkg::ST_OK))
    else $error("insert not at front");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtf_pkg::*;

  // one command beat as the host presents it
  typedef struct packed {
    op_e                op;
    logic [KEY_W-1:0]   name;
    logic [KEY_W-1:0]   path;
    logic signed [31:0] version;
    logic               load_ok;
    logic [IDX_W-1:0]   idx;
  } list_cmd_t;

  // one result beat
  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   slot;
    logic               start_load;
    logic               evicted;
    logic [KEY_W-1:0]   ename;
    logic [KEY_W-1:0]   epath;
    logic signed [31:0] ever;
    logic               eloaded;
    logic               eactive;
    logic [CNT_W-1:0]   fill;
  } list_rsp_t;

  // directed row: the command, and a hand-written result where one is given
  typedef struct packed {
    list_cmd_t cmd;
    logic      typed;
    list_rsp_t want;
  } dir_row_t;

  localparam int RandPerPhase = 250;
  localparam int DrainCycles  = 20;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [1:0]               opcode_i = '0;
  logic [KEY_W-1:0]         name_key_i = '0;
  logic [KEY_W-1:0]         path_key_i = '0;
  logic signed [KEY_W-1:0]  model_version_i = '0;
  logic                     load_ok_i = 1'b0;
  logic [IDX_W-1:0]         slot_index_i = '0;
  logic                     valid_o;
  logic [1:0]               status_o;
  logic [IDX_W-1:0]         slot_o;
  logic                     start_load_o;
  logic                     evicted_o;
  logic [KEY_W-1:0]         entry_name_o;
  logic [KEY_W-1:0]         entry_path_o;
  logic signed [KEY_W-1:0]  entry_version_o;
  logic                     entry_loaded_o;
  logic                     entry_active_o;
  logic [CNT_W-1:0]         fill_o;

  move_to_front_recent_list_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .name_key_i      (name_key_i),
    .path_key_i      (path_key_i),
    .model_version_i (model_version_i),
    .load_ok_i       (load_ok_i),
    .slot_index_i    (slot_index_i),
    .valid_o         (valid_o),
    .status_o        (status_o),
    .slot_o          (slot_o),
    .start_load_o    (start_load_o),
    .evicted_o       (evicted_o),
    .entry_name_o    (entry_name_o),
    .entry_path_o    (entry_path_o),
    .entry_version_o (entry_version_o),
    .entry_loaded_o  (entry_loaded_o),
    .entry_active_o  (entry_active_o),
    .fill_o          (fill_o)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  // shadow copy of the recent list, position 0 most recent
  logic [KEY_W-1:0]   shadow_name [CAP];
  logic [KEY_W-1:0]   shadow_path [CAP];
  logic signed [31:0] shadow_ver  [CAP];
  bit                 shadow_ld   [CAP];
  bit                 shadow_act  [CAP];
  int unsigned        shadow_cnt;

  // results still owed by the block, oldest first
  list_rsp_t   owed_results[$];
  dir_row_t    dir_rows[$];
  int          mismatches;

  // small key pools so adds and switches hit existing entries often
  logic [KEY_W-1:0] name_pool[12];
  logic [KEY_W-1:0] path_pool[12];

  function automatic list_cmd_t mk_cmd(op_e op, logic [31:0] name, logic [31:0] path,
                                       logic signed [31:0] ver, logic ok, logic [3:0] idx);
    list_cmd_t c;
    c.op = op;
    c.name = name;
    c.path = path;
    c.version = ver;
    c.load_ok = ok;
    c.idx = idx;
    return c;
  endfunction

  // hand-written results carry zero entry fields
  function automatic list_rsp_t mk_rsp(status_e st, logic [3:0] slot, logic sl, logic ev,
                                       logic [3:0] fill);
    list_rsp_t r;
    r = '0;
    r.status = st;
    r.slot = slot;
    r.start_load = sl;
    r.evicted = ev;
    r.fill = fill;
    return r;
  endfunction

  // move one shadow entry
  function automatic void copy_entry(int dst, int src);
    shadow_name[dst] = shadow_name[src];
    shadow_path[dst] = shadow_path[src];
    shadow_ver[dst]  = shadow_ver[src];
    shadow_ld[dst]   = shadow_ld[src];
    shadow_act[dst]  = shadow_act[src];
  endfunction

  // apply one command to the shadow list and work out the result beat
  function automatic list_rsp_t apply_list_cmd(list_cmd_t c);
    list_rsp_t          r;
    bit                 hit;
    int                 pos;
    logic [KEY_W-1:0]   keep_name;
    logic [KEY_W-1:0]   keep_path;
    logic signed [31:0] keep_ver;
    bit                 keep_ld;
    bit                 keep_act;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    pos = 0;
    case (c.op)
      OP_ADD: begin
        // first position matching either key wins
        for (int i = 0; i < shadow_cnt; i++)
          if (!hit && (shadow_name[i] == c.name || shadow_path[i] == c.path)) begin
            hit = 1'b1;
            pos = i;
          end
        if (hit) begin
          keep_name = shadow_name[pos];
          keep_path = shadow_path[pos];
          keep_ver  = shadow_ver[pos];
          keep_ld   = shadow_ld[pos];
          keep_act  = shadow_act[pos];
          for (int i = pos; i > 0; i--) copy_entry(i, i - 1);
          shadow_name[0] = keep_name;
          shadow_path[0] = keep_path;
          shadow_ver[0]  = keep_ver;
          shadow_ld[0]   = keep_ld;
          shadow_act[0]  = keep_act;
          r.slot = pos[IDX_W-1:0];
        end else begin
          // full list: the last entry falls off the back
          if (shadow_cnt >= CAP) begin
            shadow_cnt = CAP - 1;
            r.evicted = 1'b1;
          end
          for (int i = shadow_cnt; i > 0; i--) copy_entry(i, i - 1);
          shadow_name[0] = c.name;
          shadow_path[0] = c.path;
          shadow_ver[0]  = c.version;
          shadow_ld[0]   = 1'b0;
          shadow_act[0]  = 1'b0;
          shadow_cnt++;
          r.start_load = 1'b1;
        end
      end
      OP_SWITCH: begin
        for (int i = 0; i < shadow_cnt; i++)
          if (!hit && shadow_name[i] == c.name) begin
            hit = 1'b1;
            pos = i;
          end
        if (!hit) begin
          r.status = ST_FAIL;
        end else if (!shadow_ld[pos] && !c.load_ok) begin
          r.status = ST_FAIL;
          r.slot = pos[IDX_W-1:0];
        end else begin
          shadow_ld[pos] = 1'b1;
          for (int i = 0; i < CAP; i++) shadow_act[i] = 1'b0;
          shadow_act[pos] = 1'b1;
          r.slot = pos[IDX_W-1:0];
        end
      end
      OP_LOAD: begin
        for (int i = 0; i < shadow_cnt; i++)
          if (!hit && !shadow_ld[i]) begin
            hit = 1'b1;
            pos = i;
          end
        if (hit) begin
          shadow_ld[pos] = 1'b1;
          r.slot = pos[IDX_W-1:0];
        end else begin
          r.status = ST_FAIL;
        end
      end
      default: begin
        r.slot = c.idx;
        if (c.idx >= shadow_cnt) begin
          r.status = ST_RANGE;
        end else begin
          r.ename   = shadow_name[c.idx];
          r.epath   = shadow_path[c.idx];
          r.ever    = shadow_ver[c.idx];
          r.eloaded = shadow_ld[c.idx];
          r.eactive = shadow_act[c.idx];
        end
      end
    endcase
    r.fill = shadow_cnt[CNT_W-1:0];
    return r;
  endfunction

  function automatic string rsp_text(list_rsp_t r);
    return {$sformatf("st=%0d slot=%0d ld_start=%0b evict=%0b ",
                      r.status, r.slot, r.start_load, r.evicted),
            $sformatf("name=%h path=%h ver=%0d ld=%0b act=%0b fill=%0d",
                      r.ename, r.epath, r.ever, r.eloaded, r.eactive, r.fill)};
  endfunction

  // mostly pool keys so matches are common, sometimes a fully random key
  function automatic logic [KEY_W-1:0] pick_key(bit from_path);
    if ($urandom_range(99) < 80)
      return from_path ? path_pool[$urandom_range(11)] : name_pool[$urandom_range(11)];
    return $urandom;
  endfunction

  function automatic list_cmd_t rand_cmd();
    int  roll;
    op_e op;
    roll = $urandom_range(99);
    if (roll < 40)      op = OP_ADD;
    else if (roll < 65) op = OP_SWITCH;
    else if (roll < 80) op = OP_LOAD;
    else                op = OP_READ;
    return mk_cmd(op, pick_key(1'b0), pick_key(1'b1), $urandom, $urandom_range(1),
                  $urandom_range(15));
  endfunction

  // present one command beat, wait until it is taken, then predict its result.
  // start_i is left high so a following beat can go out back to back
  task automatic send_cmd(list_cmd_t c, logic typed, list_rsp_t want);
    list_rsp_t predicted;
    opcode_i        <= c.op;
    name_key_i      <= c.name;
    path_key_i      <= c.path;
    model_version_i <= c.version;
    load_ok_i       <= c.load_ok;
    slot_index_i    <= c.idx;
    start_i         <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    // predictor runs even for hand-checked rows so the shadow list stays in step
    predicted = apply_list_cmd(c);
    owed_results.push_back(typed ? want : predicted);
  endtask

  // sender idles on about pct of the cycles at which the block could take a beat:
  // start_i drops until the result beat of the beat just sent is out, then one
  // idle cycle after another with the given chance
  task automatic sender_gap(int pct);
    if (pct != 0) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while (valid_o !== 1'b1);
      while ($urandom_range(99) < pct) @(posedge clk_i);
    end
  endtask

  // result checker: every strobed beat must match the oldest owed result
  always @(posedge clk_i) begin
    list_rsp_t got;
    list_rsp_t want;
    if (rst_ni && valid_o) begin
      got.status     = status_e'(status_o);
      got.slot       = slot_o;
      got.start_load = start_load_o;
      got.evicted    = evicted_o;
      got.ename      = entry_name_o;
      got.epath      = entry_path_o;
      got.ever       = entry_version_o;
      got.eloaded    = entry_loaded_o;
      got.eactive    = entry_active_o;
      got.fill       = fill_o;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: %s", rsp_text(got));
      end else begin
        want = owed_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", rsp_text(want));
            $display("  actual   %s", rsp_text(got));
          end
        end
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("move_to_front_recent_list_top regression: fail");
    $finish;
  end

  initial begin
    int idle_pct[3];
    mismatches = 0;
    shadow_cnt = 0;
    for (int i = 0; i < CAP; i++) begin
      shadow_name[i] = '0;
      shadow_path[i] = '0;
      shadow_ver[i]  = '0;
      shadow_ld[i]   = 1'b0;
      shadow_act[i]  = 1'b0;
    end
    for (int i = 0; i < 12; i++) begin
      name_pool[i] = $urandom;
      path_pool[i] = $urandom;
    end

    // directed rows; hand-written results only where they are obvious
    // empty list: reads out of range, switch and load-done find nothing
    dir_rows.push_back('{mk_cmd(OP_READ, 0, 0, 0, 0, 0), 1'b1, mk_rsp(ST_RANGE, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_READ, 0, 0, 0, 0, 15), 1'b1,
                         mk_rsp(ST_RANGE, 15, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_SWITCH, 0, 0, 0, 1, 0), 1'b1,
                         mk_rsp(ST_FAIL, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_LOAD, 0, 0, 0, 0, 0), 1'b1, mk_rsp(ST_FAIL, 0, 0, 0, 0)});
    // extreme keys and versions
    dir_rows.push_back('{mk_cmd(OP_ADD, 32'h0, 32'h0, 32'sh8000_0000, 0, 0), 1'b1,
                         mk_rsp(ST_OK, 0, 1, 0, 1)});
    dir_rows.push_back('{mk_cmd(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'sh7fff_ffff, 1, 15),
                         1'b1, mk_rsp(ST_OK, 0, 1, 0, 2)});
    dir_rows.push_back('{mk_cmd(OP_READ, 0, 0, 0, 0, 0), 1'b0, mk_rsp(ST_OK, 0, 0, 0, 0)});
    // switch to an unloaded entry whose load failed
    dir_rows.push_back('{mk_cmd(OP_SWITCH, 32'hffff_ffff, 0, 0, 0, 0), 1'b1,
                         mk_rsp(ST_FAIL, 0, 0, 0, 2)});
    // switch with a good load
    dir_rows.push_back('{mk_cmd(OP_SWITCH, 32'hffff_ffff, 0, 0, 1, 0), 1'b0,
                         mk_rsp(ST_OK, 0, 0, 0, 0)});
    // add matching only on the path key, then only on the name key
    dir_rows.push_back('{mk_cmd(OP_ADD, 32'h123, 32'h0, 5, 0, 0), 1'b0,
                         mk_rsp(ST_OK, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_ADD, 32'hffff_ffff, 32'h7, 6, 0, 0), 1'b0,
                         mk_rsp(ST_OK, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_LOAD, 0, 0, 0, 0, 0), 1'b0, mk_rsp(ST_OK, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_READ, 0, 0, 0, 0, 1), 1'b0, mk_rsp(ST_OK, 0, 0, 0, 0)});
    // fill to capacity, then evict twice: the second drop takes the active entry
    for (int i = 0; i < 10; i++)
      dir_rows.push_back('{mk_cmd(OP_ADD, 32'h100 + i, 32'h200 + i,
                                  (i % 2) ? -i : i, 0, 0),
                           1'b0, mk_rsp(ST_OK, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_READ, 0, 0, 0, 0, 9), 1'b0, mk_rsp(ST_OK, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_cmd(OP_READ, 0, 0, 0, 0, 10), 1'b1,
                         mk_rsp(ST_RANGE, 10, 0, 0, 10)});

    // hold reset, then release it on a clock edge
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, back to back
    foreach (dir_rows[k])
      send_cmd(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].want);

    // random part in phases of sender idling: none, heavy, light
    idle_pct[0] = 0;
    idle_pct[1] = 76;
    idle_pct[2] = 16;
    foreach (idle_pct[p])
      for (int n = 0; n < RandPerPhase; n++) begin
        send_cmd(rand_cmd(), 1'b0, '0);
        sender_gap(idle_pct[p]);
      end

    // drain: every owed beat, then a quiet wait to catch stray beats
    start_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0)
      $display("move_to_front_recent_list_top regression: pass");
    else
      $display("move_to_front_recent_list_top regression: fail");
    $finish;
  end

endmodule
